[design/mnb_pkg.sv]
// ----------------------------------------------------------------------------
// mnb_pkg: shared definitions for the note bar LED renderer
// Action and register codes, reset values, geometry defaults, pixel type.
// ----------------------------------------------------------------------------
package mnb_pkg;

  localparam int DEF_GRID_COLUMNS = 13;
  localparam int DEF_GRID_ROWS    = 5;
  localparam int DEF_LOWEST_NOTE  = 36;
  localparam int DEF_HIGHEST_NOTE = 84;

  localparam int NOTE_W  = 7;
  localparam int NOTES   = 128;
  localparam int VEL_W   = 7;
  localparam int ACT_W   = 2;
  localparam int POS_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int PHASE_W = 9;
  localparam int SUB_W   = 8;
  localparam int IDLE_W  = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [ACT_W-1:0] ACT_MIDI  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FETCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS     = 4'd1;

  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_POLY_AT  = 4'hA;

  localparam logic [IDLE_W-1:0] TIMEOUT_RST = 16'd300;
  localparam logic [SUB_W-1:0]  TPS_RST     = 8'd5;
  localparam logic [IDLE_W-1:0] IDLE_RST    = 16'd300;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
  endfunction

endpackage

[design/mnb_ram.sv]
// ----------------------------------------------------------------------------
// mnb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module mnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mnb_scan.sv]
// ----------------------------------------------------------------------------
// mnb_scan: held-note walk for one pixel
// Streams velocity reads over the note range, one note per cycle, and sums
// the colours of notes that light the requested cell.
// ----------------------------------------------------------------------------
module mnb_scan #(
  parameter int GRID_COLUMNS = mnb_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = mnb_pkg::DEF_GRID_ROWS,
  parameter int LOWEST_NOTE  = mnb_pkg::DEF_LOWEST_NOTE,
  parameter int HIGHEST_NOTE = mnb_pkg::DEF_HIGHEST_NOTE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [mnb_pkg::POS_W-1:0]    pos,
  output logic                         active,
  output logic [mnb_pkg::NOTE_W-1:0]   rd_addr,
  input  logic [mnb_pkg::VEL_W-1:0]    rd_vel,
  output logic                         fin,
  output mnb_pkg::pix_t                pix
);
  import mnb_pkg::*;

  localparam int COL_W  = $clog2(GRID_COLUMNS);
  localparam int PROD_W = $clog2(127 * GRID_ROWS + 1);
  localparam int SPAN   = (HIGHEST_NOTE > LOWEST_NOTE) ? (HIGHEST_NOTE - LOWEST_NOTE) : 1;
  localparam int CELLS  = GRID_COLUMNS * GRID_ROWS;
  localparam logic [NOTE_W-1:0] FIRST = NOTE_W'(LOWEST_NOTE);
  localparam logic [NOTE_W-1:0] LAST  = NOTE_W'(HIGHEST_NOTE);

  logic [COL_W-1:0]  col_tab  [NOTES];
  logic [CHAN_W-1:0] red_tab  [NOTES];
  logic [CHAN_W-1:0] grn_tab  [NOTES];
  logic [CHAN_W-1:0] blu_tab  [NOTES];
  logic [COL_W-1:0]  gcol_tab [NOTES];
  logic [PROD_W-1:0] thr_tab  [NOTES];

  for (genvar i = 0; i < NOTES; i++) begin : g_tab
    localparam int PCT    = 100 * (i - LOWEST_NOTE) / SPAN;
    localparam int COLRAW = GRID_COLUMNS * PCT / 100;
    localparam int COL    = (i <= LOWEST_NOTE) ? 0 :
                            (i >= HIGHEST_NOTE) ? GRID_COLUMNS - 1 :
                            (COLRAW <= 0) ? 0 : COLRAW - 1;
    localparam int RED    = (i <= 60) ? 255 * i / 60 : 0;
    localparam int BLU    = (i >= 40 && i <= 100) ? 255 * (i - 40) / 60 : 0;
    localparam int GRAW   = (i >= 60) ? 255 * (i - 60) / 60 : 0;
    localparam int GRN    = (GRAW > 255) ? 255 : GRAW;
    localparam int PROW   = i / GRID_COLUMNS;
    localparam int PCOL   = i % GRID_COLUMNS;
    localparam int GCOL   = (PROW % 2 == 0) ? GRID_COLUMNS - 1 - PCOL : PCOL;
    localparam int THR    = (i < CELLS) ? 127 * (GRID_ROWS - PROW) : 0;
    assign col_tab[i]  = COL_W'(COL);
    assign red_tab[i]  = CHAN_W'(RED);
    assign grn_tab[i]  = CHAN_W'(GRN);
    assign blu_tab[i]  = CHAN_W'(BLU);
    assign gcol_tab[i] = COL_W'(GCOL);
    assign thr_tab[i]  = PROD_W'(THR);
  end

  logic              issuing;
  logic [NOTE_W-1:0] ia;
  logic              p1;
  logic [NOTE_W-1:0] na;
  logic [PROD_W-1:0] thr;
  logic [COL_W-1:0]  gcol;
  pix_t              acc;
  pix_t              acc_next;
  logic [PROD_W-1:0] prod;
  logic              hit;

  assign rd_addr = ia;
  assign prod    = PROD_W'(rd_vel) * PROD_W'(GRID_ROWS);
  assign hit     = p1 && (rd_vel != '0) && (col_tab[na] == gcol) && (prod >= thr);
  assign fin     = p1 && (na == LAST);
  assign pix     = acc_next;

  always_comb begin
    acc_next = acc;
    if (hit) begin
      acc_next.red   = sat_add(acc.red, red_tab[na]);
      acc_next.green = sat_add(acc.green, grn_tab[na]);
      acc_next.blue  = sat_add(acc.blue, blu_tab[na]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      issuing <= 1'b0;
      p1      <= 1'b0;
    end else begin
      p1 <= issuing;
      if (go && !active) begin
        active  <= 1'b1;
        issuing <= 1'b1;
      end else begin
        if (issuing && ia == LAST) begin
          issuing <= 1'b0;
        end
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    na <= ia;
    if (go && !active) begin
      ia   <= FIRST;
      thr  <= thr_tab[pos];
      gcol <= gcol_tab[pos];
      acc  <= '0;
    end else begin
      if (issuing) begin
        ia <= ia + 1'b1;
      end
      acc <= acc_next;
    end
  end

endmodule

[design/midi_note_bar_led_renderer_unit.sv]
// ----------------------------------------------------------------------------
// midi_note_bar_led_renderer_unit: note bar LED renderer, top level
// Tracks held-note velocities and idle time, serves one LED colour per fetch.
// ----------------------------------------------------------------------------
// MIDI and tick commands never raise busy. A fetch outside the
// string, or while the screensaver is on, returns its result with done in the
// next cycle. A fetch in active mode reads the velocity memory one note per
// cycle over LOWEST_NOTE..HIGHEST_NOTE, so busy stays high for the whole walk
// and done rises in the cycle in which busy falls. done lasts
// one cycle and cannot be held off; a new command may start in that cycle.
// cfg_ready is always high.
module midi_note_bar_led_renderer_unit #(
  parameter int GRID_COLUMNS = mnb_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = mnb_pkg::DEF_GRID_ROWS,
  parameter int LOWEST_NOTE  = mnb_pkg::DEF_LOWEST_NOTE,
  parameter int HIGHEST_NOTE = mnb_pkg::DEF_HIGHEST_NOTE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mnb_pkg::ACT_W-1:0]       action,
  input  logic [7:0]                      status_byte,
  input  logic [mnb_pkg::NOTE_W-1:0]      note_number,
  input  logic [mnb_pkg::VEL_W-1:0]       note_velocity,
  input  logic [mnb_pkg::POS_W-1:0]       led_position,
  output logic                            done,
  output logic [mnb_pkg::CHAN_W-1:0]      led_red,
  output logic [mnb_pkg::CHAN_W-1:0]      led_green,
  output logic [mnb_pkg::CHAN_W-1:0]      led_blue,
  output logic                            saver_shown,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mnb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mnb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mnb_pkg::*;

  localparam int  CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam bit  EMPTY = HIGHEST_NOTE < LOWEST_NOTE;

  logic [IDLE_W-1:0]  timeout;
  logic [SUB_W-1:0]   tps;
  logic [PHASE_W-1:0] phase;
  logic [SUB_W-1:0]   subsec;
  logic [SUB_W-1:0]   subsec_next;
  logic [IDLE_W-1:0]  idle;
  logic [NOTES-1:0]   vld;
  logic               vld_q;

  logic               take;
  logic [3:0]         msg_type;
  logic               is_note;
  logic               mem_we;
  logic [VEL_W-1:0]   mem_wdata;
  logic [NOTE_W-1:0]  rd_addr;
  logic [VEL_W-1:0]   mem_rdata;
  logic [VEL_W-1:0]   vel_eff;
  logic               saver_on;
  logic               in_range;
  logic               fetch;
  logic               go_scan;
  logic               scan_active;
  logic               scan_fin;
  pix_t               scan_pix;

  assign take      = start && !busy;
  assign cfg_ready = 1'b1;
  assign busy      = scan_active;
  assign msg_type  = status_byte[7:4];
  assign is_note   = (msg_type == MIDI_NOTE_OFF) || (msg_type == MIDI_NOTE_ON) ||
                     (msg_type == MIDI_POLY_AT);
  assign mem_we    = take && (action == ACT_MIDI) && is_note;
  assign mem_wdata = (msg_type == MIDI_NOTE_OFF) ? '0 : note_velocity;
  assign saver_on  = idle >= timeout;
  assign in_range  = 32'(led_position) < 32'(CELLS);
  assign fetch     = take && (action == ACT_FETCH);
  assign go_scan   = fetch && in_range && !saver_on && !EMPTY;
  assign vel_eff   = vld_q ? mem_rdata : '0;
  assign subsec_next = subsec + 1'b1;

  mnb_ram #(.WIDTH(VEL_W), .DEPTH(NOTES)) u_vel_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(note_number),
    .wdata(mem_wdata),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  mnb_scan #(
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS),
    .LOWEST_NOTE (LOWEST_NOTE),
    .HIGHEST_NOTE(HIGHEST_NOTE)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .go     (go_scan),
    .pos    (led_position),
    .active (scan_active),
    .rd_addr(rd_addr),
    .rd_vel (vel_eff),
    .fin    (scan_fin),
    .pix    (scan_pix)
  );

  always_ff @(posedge clk) begin
    vld_q <= vld[rd_addr];
  end

  // config, tick and note state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RST;
      tps     <= TPS_RST;
      phase   <= '0;
      subsec  <= '0;
      idle    <= IDLE_RST;
      vld     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout <= cfg_data;
          CFG_TPS:     tps     <= cfg_data[SUB_W-1:0];
          default: ;
        endcase
      end
      if (mem_we) begin
        vld[note_number] <= 1'b1;
        idle             <= '0;
      end
      if (take && action == ACT_TICK) begin
        phase <= phase + 1'b1;
        if (subsec_next >= tps || subsec_next == '0) begin
          subsec <= '0;
          if (idle < timeout) begin
            idle <= idle + 1'b1;
          end
        end else begin
          subsec <= subsec_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      saver_shown <= 1'b0;
    end else begin
      done        <= scan_fin || (fetch && !go_scan);
      saver_shown <= fetch && in_range && saver_on;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fin) begin
      led_red   <= scan_pix.red;
      led_green <= scan_pix.green;
      led_blue  <= scan_pix.blue;
    end else if (fetch && in_range && saver_on) begin
      led_red   <= phase[7:0];
      led_green <= {phase[6:0], 1'b0};
      led_blue  <= phase[8:1];
    end else if (fetch) begin
      led_red   <= '0;
      led_green <= '0;
      led_blue  <= '0;
    end
  end

endmodule

[design/mnb_chk.sv]
// ----------------------------------------------------------------------------
// mnb_chk: port-level checks for the note bar LED renderer
// Watches command, result and busy timing; bound to the top level.
// ----------------------------------------------------------------------------
module mnb_chk #(
  parameter int GRID_COLUMNS = mnb_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = mnb_pkg::DEF_GRID_ROWS
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [mnb_pkg::ACT_W-1:0]      action,
  input logic [mnb_pkg::POS_W-1:0]      led_position,
  input logic                           done,
  input logic [mnb_pkg::CHAN_W-1:0]     led_red,
  input logic [mnb_pkg::CHAN_W-1:0]     led_green,
  input logic [mnb_pkg::CHAN_W-1:0]     led_blue,
  input logic                           saver_shown
);
  import mnb_pkg::*;

  localparam int CELLS = GRID_COLUMNS * GRID_ROWS;

  a_tick_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_TICK |=> !done)
    else $error("result after tick");

  a_shown_with_done: assert property (@(posedge clk) disable iff (rst)
    saver_shown |-> done)
    else $error("saver_shown without done");

  a_scan_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without result");

  a_off_string_black: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_FETCH && 32'(led_position) >= 32'(CELLS)
    |=> done && led_red == '0 && led_green == '0 && led_blue == '0 && !saver_shown)
    else $error("fetch past string not black");

endmodule

bind midi_note_bar_led_renderer_unit mnb_chk #(
  .GRID_COLUMNS(GRID_COLUMNS),
  .GRID_ROWS   (GRID_ROWS)
) u_mnb_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .action      (action),
  .led_position(led_position),
  .done        (done),
  .led_red     (led_red),
  .led_green   (led_green),
  .led_blue    (led_blue),
  .saver_shown (saver_shown)
);

[tb/sv/tb_midi_note_bar_led_renderer_unit.sv]
// ----------------------------------------------------------------------------
// tb_midi_note_bar_led_renderer_unit: note bar LED renderer testbench
// Drives MIDI, tick and pixel fetch commands with random bursts and gaps,
// predicts every fetched pixel from a local copy of the note table, tick phase
// and idle counter, and checks each result as it is strobed out.
// ----------------------------------------------------------------------------
module tb_midi_note_bar_led_renderer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mnb_pkg::*;

  localparam int COLS    = DEF_GRID_COLUMNS;
  localparam int ROWS    = DEF_GRID_ROWS;
  localparam int LO_NOTE = DEF_LOWEST_NOTE;
  localparam int HI_NOTE = DEF_HIGHEST_NOTE;
  localparam int PIXELS  = COLS * ROWS;

  localparam logic [ACT_W-1:0]     ACT_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 4'd9;
  localparam logic [3:0]           MIDI_CTRL_CHG = 4'hB;

  localparam int SETTLE_CYCLES = HI_NOTE - LO_NOTE + 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 140;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [7:0]        status;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  typedef struct packed {
    pix_t px;
    logic saver;
  } led_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ACT_W-1:0]      action = ACT_MIDI;
  logic [7:0]            status_byte = '0;
  logic [NOTE_W-1:0]     note_number = '0;
  logic [VEL_W-1:0]      note_velocity = '0;
  logic [POS_W-1:0]      led_position = '0;
  logic                  done;
  logic [CHAN_W-1:0]     led_red;
  logic [CHAN_W-1:0]     led_green;
  logic [CHAN_W-1:0]     led_blue;
  logic                  saver_shown;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  midi_note_bar_led_renderer_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .status_byte(status_byte), .note_number(note_number),
    .note_velocity(note_velocity), .led_position(led_position), .done(done),
    .led_red(led_red), .led_green(led_green), .led_blue(led_blue),
    .saver_shown(saver_shown), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [VEL_W-1:0]   held_vel [NOTES];
  logic [PHASE_W-1:0] phase_cnt;
  logic [SUB_W-1:0]   sub_cnt;
  logic [IDLE_W-1:0]  idle_secs;
  logic [IDLE_W-1:0]  saver_after;
  logic [SUB_W-1:0]   ticks_per_sec;

  led_res_t pixel_q[$];
  led_res_t want;
  int       errors = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int sat8(input int v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int note_column(input int n);
    int pct;
    int col;
    if (n <= LO_NOTE) return 0;
    if (n >= HI_NOTE) return COLS - 1;
    pct = 100 * (n - LO_NOTE) / (HI_NOTE - LO_NOTE);
    col = COLS * pct / 100;
    return (col == 0) ? 0 : col - 1;
  endfunction

  function automatic led_res_t render_pixel(input int p);
    led_res_t r;
    int row, c, gcol, bars, v, n;
    int sr, sg, sb;
    r = '0;
    if (p >= PIXELS) return r;
    if (idle_secs >= saver_after) begin
      r.px.red   = phase_cnt[7:0];
      r.px.green = {phase_cnt[6:0], 1'b0};
      r.px.blue  = phase_cnt[8:1];
      r.saver    = 1'b1;
      return r;
    end
    row  = p / COLS;
    c    = p % COLS;
    gcol = (row % 2 == 0) ? COLS - 1 - c : c;
    sr = 0;
    sg = 0;
    sb = 0;
    for (n = LO_NOTE; n <= HI_NOTE && n < NOTES; n++) begin
      v = int'(held_vel[n]);
      if (v == 0 || note_column(n) != gcol) continue;
      bars = v * ROWS / 127;
      if (row + bars < ROWS) continue;
      if (n <= 60) sr = sat8(sr + 255 * n / 60);
      if (n >= 40 && n <= 100) sb = sat8(sb + 255 * (n - 40) / 60);
      if (n >= 60) sg = sat8(sg + sat8(255 * (n - 60) / 60));
    end
    r.px.red   = sr[7:0];
    r.px.green = sg[7:0];
    r.px.blue  = sb[7:0];
    return r;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NOTES; i++) held_vel[i] = '0;
    phase_cnt     = '0;
    sub_cnt       = '0;
    idle_secs     = IDLE_RST;
    saver_after   = TIMEOUT_RST;
    ticks_per_sec = TPS_RST;
  endtask

  task automatic apply_cmd(input cmd_t c);
    logic [3:0] kind;
    kind = c.status[7:4];
    case (c.act)
      ACT_MIDI: begin
        if (kind == MIDI_NOTE_OFF || kind == MIDI_NOTE_ON || kind == MIDI_POLY_AT) begin
          idle_secs = '0;
          held_vel[c.note] = (kind == MIDI_NOTE_OFF) ? '0 : c.vel;
        end
      end
      ACT_TICK: begin
        phase_cnt = phase_cnt + 1'b1;
        sub_cnt   = sub_cnt + 1'b1;
        if (sub_cnt >= ticks_per_sec || sub_cnt == '0) begin
          sub_cnt = '0;
          if (idle_secs < saver_after) idle_secs = idle_secs + 1'b1;
        end
      end
      ACT_FETCH: pixel_q.push_back(render_pixel(int'(c.pos)));
      default: ;
    endcase
  endtask

  function automatic cmd_t mk_cmd(input logic [ACT_W-1:0] a, input logic [7:0] s,
                                  input logic [NOTE_W-1:0] n, input logic [VEL_W-1:0] v,
                                  input logic [POS_W-1:0] p);
    cmd_t c;
    c.act = a;
    c.status = s;
    c.note = n;
    c.vel = v;
    c.pos = p;
    return c;
  endfunction

  function automatic cmd_t fetch_at(input logic [POS_W-1:0] p);
    return mk_cmd(ACT_FETCH, 8'($urandom), NOTE_W'($urandom), VEL_W'($urandom), p);
  endfunction

  function automatic cmd_t note_msg(input logic [3:0] kind, input int n, input int v);
    return mk_cmd(ACT_MIDI, {kind, 4'($urandom)}, n[NOTE_W-1:0], v[VEL_W-1:0],
                  POS_W'($urandom));
  endfunction

  function automatic cmd_t tick_cmd();
    return mk_cmd(ACT_TICK, 8'($urandom), NOTE_W'($urandom), VEL_W'($urandom),
                  POS_W'($urandom));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int k;
    int sel;
    logic [3:0] kind;
    c = mk_cmd(ACT_W'($urandom), 8'($urandom), NOTE_W'($urandom), VEL_W'($urandom),
               POS_W'($urandom));
    k = $urandom_range(0, 99);
    if (k < 38) begin
      sel = $urandom_range(0, 99);
      kind = (sel < 68) ? MIDI_NOTE_ON : (sel < 83) ? MIDI_NOTE_OFF :
             (sel < 91) ? MIDI_POLY_AT : 4'($urandom);
      c.act = ACT_MIDI;
      c.status[7:4] = kind;
      if ($urandom_range(0, 9) < 8) c.note = NOTE_W'($urandom_range(LO_NOTE - 4, HI_NOTE + 4));
      sel = $urandom_range(0, 9);
      c.vel = (sel == 0) ? 7'd0 : (sel == 1) ? 7'd127 : 7'($urandom_range(1, 127));
    end else if (k < 62) begin
      c.act = ACT_TICK;
    end else if (k < 96) begin
      c.act = ACT_FETCH;
      c.pos = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, PIXELS - 1));
    end else begin
      c.act = ACT_SPARE;
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    action        <= c.act;
    status_byte   <= c.status;
    note_number   <= c.note;
    note_velocity <= c.vel;
    led_position  <= c.pos;
    do @(posedge clk); while (busy);
    apply_cmd(c);
  endtask

  task automatic wait_results_idle(input bit settle);
    start <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIMEOUT: saver_after = data;
      CFG_TPS:     ticks_per_sec = data[SUB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int timeout, input int tps);
    wait_results_idle(1'b1);
    write_reg(CFG_TIMEOUT, timeout[CFG_DATA_W-1:0]);
    write_reg(CFG_TPS, {8'($urandom), tps[7:0]});
    if ($urandom_range(0, 1) == 1) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel", 32'({led_red, led_green, led_blue}), 32'd0);
      end else begin
        want = pixel_q.pop_front();
        if (led_red !== want.px.red)
          report_mismatch("led_red", 32'(led_red), 32'(want.px.red));
        if (led_green !== want.px.green)
          report_mismatch("led_green", 32'(led_green), 32'(want.px.green));
        if (led_blue !== want.px.blue)
          report_mismatch("led_blue", 32'(led_blue), 32'(want.px.blue));
        if (saver_shown !== want.saver)
          report_mismatch("saver_shown", 32'(saver_shown), 32'(want.saver));
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_saver_after_reset();
    send_cmd(fetch_at(7'd0));
    send_cmd(tick_cmd());
    send_cmd(tick_cmd());
    send_cmd(fetch_at(7'd64));
    send_cmd(fetch_at(7'd65));
    send_cmd(fetch_at(7'd127));
    send_cmd(mk_cmd(ACT_SPARE, 8'hFF, 7'h7F, 7'h7F, 7'h7F));
    send_cmd(note_msg(MIDI_CTRL_CHG, 60, 100));
    send_cmd(fetch_at(7'd30));
  endtask

  task automatic test_note_messages();
    send_cmd(note_msg(MIDI_NOTE_ON, LO_NOTE, 127));
    send_cmd(note_msg(MIDI_NOTE_ON, LO_NOTE - 1, 127));
    send_cmd(note_msg(MIDI_NOTE_ON, HI_NOTE, 127));
    send_cmd(note_msg(MIDI_POLY_AT, 60, 64));
    send_cmd(note_msg(MIDI_NOTE_ON, 127, 127));
    send_cmd(note_msg(MIDI_NOTE_OFF, 0, 127));
    send_cmd(fetch_at(7'd12));
    send_cmd(fetch_at(7'd0));
    send_cmd(fetch_at(7'd52));
    send_cmd(fetch_at(7'd64));
    send_cmd(note_msg(MIDI_NOTE_OFF, LO_NOTE, 127));
    send_cmd(fetch_at(7'd12));
  endtask

  task automatic test_config_extremes();
    set_config(0, 255);
    send_cmd(fetch_at(7'd20));
    send_cmd(tick_cmd());
    send_cmd(fetch_at(7'd40));
    set_config(65535, 0);
    send_cmd(note_msg(MIDI_NOTE_ON, 72, 100));
    send_cmd(tick_cmd());
    send_cmd(tick_cmd());
    send_cmd(fetch_at(7'd36));
  endtask

  task automatic test_random_traffic();
    int timeout;
    int tps;
    int pause_at;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin timeout = 300;   tps = 5;   end
        1: begin timeout = 1;     tps = 1;   end
        2: begin timeout = 2;     tps = 3;   end
        3: begin timeout = 0;     tps = 0;   end
        4: begin timeout = 65535; tps = 255; end
        5: begin timeout = 4;     tps = 2;   end
        6: begin timeout = 3;     tps = 1;   end
        default: begin timeout = $urandom_range(0, 6); tps = $urandom_range(0, 4); end
      endcase
      set_config(timeout, tps);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) wait_results_idle(1'b0);
        send_cmd(rand_cmd());
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_saver_after_reset();
    test_note_messages();
    test_config_extremes();
    test_random_traffic();
    wait_results_idle(1'b1);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
